FILE: rtl/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg: shared types and constants for the time-ordered event queue
// Event record, command and status codes, and the broadcast control bundle.
// ----------------------------------------------------------------------------
package toeq_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int KIND_W  = 8;
    localparam int AREA_W  = 8;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int OCC_OUT_W = 7;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  time_val;
        logic [AREA_W-1:0]  area;
        logic [KIND_W-1:0]  kind;
    } event_t;

    // Broadcast from the controller to every cell in the row
    typedef struct packed {
        logic   insert;
        logic   remove;
        event_t ev;
    } ctl_t;

endpackage

FILE: rtl/toeq_cell.sv
// ----------------------------------------------------------------------------
// toeq_cell: one slot of the sorted event row
// Holds one event, compares its time with a broadcast insert, and takes its
// next value from itself, the new event, or the left or right neighbor.
// ----------------------------------------------------------------------------
module toeq_cell
(
    input  logic            clk,
    input  toeq_pkg::ctl_t  ctl,
    input  logic            occupied,
    input  logic            left_after,
    input  toeq_pkg::event_t left_ev,
    input  toeq_pkg::event_t right_ev,
    output toeq_pkg::event_t ev,
    output logic            after
);

    toeq_pkg::event_t ev_reg;
    toeq_pkg::event_t ev_next;

    // Stored event sorts no later than the incoming one: it stays in place
    assign after = occupied && (ev_reg.time_val <= ctl.ev.time_val);
    assign ev    = ev_reg;

    always_comb
    begin
        ev_next = ev_reg;
        if (ctl.insert)
        begin
            if (!after)
            begin
                ev_next = left_after ? ctl.ev : left_ev;
            end
        end
        else if (ctl.remove)
        begin
            ev_next = right_ev;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

endmodule

FILE: rtl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue: sorted discrete-event queue
// Row of compare-and-shift cells kept in time order, with a registered
// result stage on the output stream.
// ----------------------------------------------------------------------------
// Every command (insert or remove of the earliest event) acts on the whole
// row at once: all cells compare their stored time against the new event
// and shift by one place in the same edge, so a new transaction is taken in
// every cycle while the result register is free or being drained. Each
// command yields exactly one result transaction. An insert lands behind all
// stored events of equal or earlier time; an insert into a full queue is
// dropped with a full status, and a remove from an empty queue returns an
// empty status with zero event fields. Reset clears the occupancy count and
// the result valid flag; slot contents need no clearing.
module time_ordered_event_queue
#(
    parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] event_kind_in, [15:8] event_area_in, [63:16] event_time_in,
    // [95:64] event_delay_in
    input  logic [toeq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] event_kind_out, [15:8] event_area_out, [63:16] event_time_out,
    // [95:64] event_delay_out, [102:96] occupancy_out, [103] zero
    output logic [toeq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    logic             is_remove;
    logic             full;
    logic             empty;
    toeq_pkg::ctl_t   ctl;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [1:0]       out_status_next;
    toeq_pkg::event_t out_ev_reg;
    toeq_pkg::event_t out_ev_next;
    logic [OCC_W-1:0] out_occ_reg;

    logic [OCC_W+toeq_pkg::OCC_OUT_W-1:0] occ_wide;

    toeq_pkg::event_t cell_ev [QUEUE_DEPTH];
    logic             cell_after [QUEUE_DEPTH];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_remove     = (s_axis_tuser == toeq_pkg::CMD_REMOVE);
    assign full          = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty         = (occ_reg == '0);

    always_comb
    begin
        ctl.insert       = accept && !is_remove && !full;
        ctl.remove       = accept && is_remove && !empty;
        ctl.ev.kind      = s_axis_tdata[7:0];
        ctl.ev.area      = s_axis_tdata[15:8];
        ctl.ev.time_val  = s_axis_tdata[63:16];
        ctl.ev.delay     = s_axis_tdata[95:64];
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctl.remove)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_comb
    begin
        out_status_next = toeq_pkg::STATUS_OK;
        out_ev_next     = '0;
        if (is_remove)
        begin
            if (empty)
            begin
                out_status_next = toeq_pkg::STATUS_EMPTY;
            end
            else
            begin
                out_ev_next = cell_ev[0];
            end
        end
        else if (full)
        begin
            out_status_next = toeq_pkg::STATUS_FULL;
        end
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic             occupied;
            logic             left_after;
            toeq_pkg::event_t left_ev;
            toeq_pkg::event_t right_ev;

            assign occupied = (OCC_W'(i) < occ_reg);

            if (i == 0)
            begin : g_head
                assign left_after = 1'b1;
                assign left_ev    = '0;
            end
            else
            begin : g_body
                assign left_after = cell_after[i-1];
                assign left_ev    = cell_ev[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_ev = '0;
            end
            else
            begin : g_inner
                assign right_ev = cell_ev[i+1];
            end

            toeq_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occupied),
                .left_after (left_after),
                .left_ev    (left_ev),
                .right_ev   (right_ev),
                .ev         (cell_ev[i]),
                .after      (cell_after[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transaction is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_ev_reg     <= out_ev_next;
            out_occ_reg    <= occ_next;
        end
    end

    assign occ_wide      = {{toeq_pkg::OCC_OUT_W{1'b0}}, out_occ_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, occ_wide[toeq_pkg::OCC_OUT_W-1:0], out_ev_reg.delay,
                            out_ev_reg.time_val, out_ev_reg.area, out_ev_reg.kind};

endmodule
